@@ design/slx_pkg.sv @@
// shared types, character codes and helper functions for the script lexer
package slx_pkg;

  // field widths and saturation limits
  localparam int POS_W  = 24;
  localparam int LINE_W = 20;
  localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};
  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

  // bundle queue between scanner and emitter
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int MAX_ITEMS  = 3;

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // token kinds
  typedef enum logic [1:0] {
    KIND_OP   = 2'd0,
    KIND_WORD = 2'd1,
    KIND_STR  = 2'd2,
    KIND_ERR  = 2'd3
  } slx_kind_t;

  // one result word
  typedef struct packed {
    slx_kind_t         kind;
    logic [7:0]        ch;
    logic              present;
    logic              first;
    logic              tend;
    logic [POS_W-1:0]  offset;
    logic [LINE_W-1:0] line;
  } slx_item_t;

  // all result words caused by one input character
  typedef struct packed {
    slx_item_t [MAX_ITEMS-1:0] items;
    logic [1:0]                cnt;
  } slx_bundle_t;

  // separators
  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
  endfunction

  // single-character operators
  function automatic logic is_operator(input logic [7:0] c);
    return c inside {8'h2C, 8'h3D, 8'h28, 8'h29, 8'h3B, 8'h7B, 8'h7D,
                     8'h3C, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3E};
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W-1:0] v);
    return (v == POS_MAX) ? v : v + {{(POS_W-1){1'b0}}, 1'b1};
  endfunction

  function automatic logic [LINE_W-1:0] sat_line(input logic [LINE_W-1:0] v);
    return (v == LINE_MAX) ? v : v + {{(LINE_W-1){1'b0}}, 1'b1};
  endfunction

  function automatic slx_item_t mk_item(input slx_kind_t kind, input logic [7:0] ch,
                                        input logic present, input logic first,
                                        input logic tend, input logic [POS_W-1:0] offset,
                                        input logic [LINE_W-1:0] line);
    slx_item_t it;
    it.kind    = kind;
    it.ch      = present ? ch : CH_NUL;
    it.present = present;
    it.first   = first;
    it.tend    = tend;
    it.offset  = offset;
    it.line    = line;
    return it;
  endfunction

endpackage

@@ design/slx_scan.sv @@
// front end: classifies each character and builds the bundle of words it causes
module slx_scan import slx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [7:0]  in_char,
  input  logic        in_is_final,
  output logic        bnd_push,
  output slx_bundle_t bnd
);

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_COMMENT = 3'd1,
    M_WORD    = 3'd2,
    M_STRING  = 3'd3,
    M_STRQ    = 3'd4
  } mode_t;

  mode_t             mode_r, mode_nxt;
  logic              slash_r, slash_nxt;
  logic [7:0]        held_r, held_nxt;
  logic              hvalid_r, hvalid_nxt;
  logic              hfirst_r, hfirst_nxt;
  logic [POS_W-1:0]  spos_r, spos_nxt;
  logic [LINE_W-1:0] sline_r, sline_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [2:0]        n_items;
  slx_item_t [MAX_ITEMS-1:0] items;

  // next state and the words this character causes, in output order
  always_comb begin
    logic to_idle;
    mode_nxt   = mode_r;
    slash_nxt  = slash_r;
    held_nxt   = held_r;
    hvalid_nxt = hvalid_r;
    hfirst_nxt = hfirst_r;
    spos_nxt   = spos_r;
    sline_nxt  = sline_r;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    to_idle    = 1'b0;
    n_items    = 3'd0;
    items      = '0;

    // resolve a held slash or continue the open token
    if (slash_nxt) begin
      slash_nxt = 1'b0;
      if (in_char == CH_SLASH) begin
        mode_nxt = M_COMMENT;
      end else begin
        items[n_items[1:0]] = mk_item(KIND_OP, CH_SLASH, 1'b1, 1'b1, 1'b1,
                                      spos_nxt, sline_nxt);
        n_items = n_items + 3'd1;
        to_idle = 1'b1;
      end
    end else begin
      case (mode_nxt)
        M_COMMENT: begin
          if (in_char == CH_LF) begin
            line_nxt = sat_line(line_nxt);
            mode_nxt = M_IDLE;
          end
        end
        M_WORD: begin
          if (is_space(in_char) || is_operator(in_char) || in_char == CH_HASH) begin
            if (hvalid_nxt) begin
              items[n_items[1:0]] = mk_item(KIND_WORD, held_nxt, 1'b1, hfirst_nxt, 1'b1,
                                            spos_nxt, sline_nxt);
              n_items = n_items + 3'd1;
            end
            hvalid_nxt = 1'b0;
            hfirst_nxt = 1'b0;
            held_nxt   = CH_NUL;
            mode_nxt   = M_IDLE;
            to_idle    = 1'b1;
          end else begin
            if (hvalid_nxt) begin
              items[n_items[1:0]] = mk_item(KIND_WORD, held_nxt, 1'b1, hfirst_nxt, 1'b0,
                                            spos_nxt, sline_nxt);
              n_items = n_items + 3'd1;
              hfirst_nxt = 1'b0;
            end else begin
              hfirst_nxt = 1'b1;
            end
            held_nxt   = in_char;
            hvalid_nxt = 1'b1;
          end
        end
        M_STRING: begin
          if (in_char == CH_QUOTE) begin
            mode_nxt = M_STRQ;
          end else begin
            if (hvalid_nxt) begin
              items[n_items[1:0]] = mk_item(KIND_STR, held_nxt, 1'b1, hfirst_nxt, 1'b0,
                                            spos_nxt, sline_nxt);
              n_items = n_items + 3'd1;
              hfirst_nxt = 1'b0;
            end else begin
              hfirst_nxt = 1'b1;
            end
            held_nxt   = in_char;
            hvalid_nxt = 1'b1;
          end
        end
        M_STRQ: begin
          if (in_char == CH_QUOTE) begin
            // doubled quote stands for one literal quote
            if (hvalid_nxt) begin
              items[n_items[1:0]] = mk_item(KIND_STR, held_nxt, 1'b1, hfirst_nxt, 1'b0,
                                            spos_nxt, sline_nxt);
              n_items = n_items + 3'd1;
              hfirst_nxt = 1'b0;
            end else begin
              hfirst_nxt = 1'b1;
            end
            held_nxt   = CH_QUOTE;
            hvalid_nxt = 1'b1;
            mode_nxt   = M_STRING;
          end else begin
            // string closed at this position
            if (hvalid_nxt) begin
              items[n_items[1:0]] = mk_item(KIND_STR, held_nxt, 1'b1, hfirst_nxt, 1'b1,
                                            pos_r, sline_nxt);
            end else begin
              items[n_items[1:0]] = mk_item(KIND_STR, CH_NUL, 1'b0, 1'b1, 1'b1,
                                            pos_r, sline_nxt);
            end
            n_items    = n_items + 3'd1;
            hvalid_nxt = 1'b0;
            hfirst_nxt = 1'b0;
            held_nxt   = CH_NUL;
            mode_nxt   = M_IDLE;
            to_idle    = 1'b1;
          end
        end
        default: begin
          mode_nxt = M_IDLE;
          to_idle  = 1'b1;
        end
      endcase
    end

    // character seen between tokens
    if (to_idle) begin
      if (is_space(in_char)) begin
        if (in_char == CH_LF) begin
          line_nxt = sat_line(line_nxt);
        end
      end else if (in_char == CH_HASH) begin
        mode_nxt = M_COMMENT;
      end else if (in_char == CH_SLASH) begin
        slash_nxt = 1'b1;
        spos_nxt  = pos_r;
        sline_nxt = line_nxt;
      end else if (is_operator(in_char)) begin
        items[n_items[1:0]] = mk_item(KIND_OP, in_char, 1'b1, 1'b1, 1'b1,
                                      pos_r, line_nxt);
        n_items = n_items + 3'd1;
      end else begin
        spos_nxt  = pos_r;
        sline_nxt = line_nxt;
        if (in_char == CH_QUOTE) begin
          hvalid_nxt = 1'b0;
          hfirst_nxt = 1'b0;
          mode_nxt   = M_STRING;
        end else begin
          held_nxt   = in_char;
          hvalid_nxt = 1'b1;
          hfirst_nxt = 1'b1;
          mode_nxt   = M_WORD;
        end
      end
    end

    // flush at end of text, then back to reset state
    if (in_is_final) begin
      if (slash_nxt) begin
        items[n_items[1:0]] = mk_item(KIND_OP, CH_SLASH, 1'b1, 1'b1, 1'b1,
                                      spos_nxt, sline_nxt);
        n_items = n_items + 3'd1;
      end
      if (mode_nxt == M_WORD) begin
        if (hvalid_nxt) begin
          items[n_items[1:0]] = mk_item(KIND_WORD, held_nxt, 1'b1, hfirst_nxt, 1'b1,
                                        spos_nxt, sline_nxt);
          n_items = n_items + 3'd1;
        end
      end else if (mode_nxt == M_STRING) begin
        items[n_items[1:0]] = mk_item(KIND_ERR, CH_NUL, 1'b0, 1'b1, 1'b1,
                                      spos_nxt, sline_nxt);
        n_items = n_items + 3'd1;
      end else if (mode_nxt == M_STRQ) begin
        if (hvalid_nxt) begin
          items[n_items[1:0]] = mk_item(KIND_STR, held_nxt, 1'b1, hfirst_nxt, 1'b1,
                                        sat_pos(pos_r), sline_nxt);
        end else begin
          items[n_items[1:0]] = mk_item(KIND_STR, CH_NUL, 1'b0, 1'b1, 1'b1,
                                        sat_pos(pos_r), sline_nxt);
        end
        n_items = n_items + 3'd1;
      end
      mode_nxt   = M_IDLE;
      slash_nxt  = 1'b0;
      held_nxt   = CH_NUL;
      hvalid_nxt = 1'b0;
      hfirst_nxt = 1'b0;
      spos_nxt   = '0;
      sline_nxt  = '0;
      pos_nxt    = '0;
      line_nxt   = '0;
    end else begin
      pos_nxt = sat_pos(pos_r);
    end
  end

  // bundle toward the queue
  assign bnd_push  = acc && (n_items != 3'd0);
  assign bnd.items = items;
  assign bnd.cnt   = n_items[1:0];

  // scanner state, advanced once per accepted character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      slash_r  <= 1'b0;
      held_r   <= CH_NUL;
      hvalid_r <= 1'b0;
      hfirst_r <= 1'b0;
      spos_r   <= '0;
      sline_r  <= '0;
      pos_r    <= '0;
      line_r   <= '0;
    end else if (acc) begin
      mode_r   <= mode_nxt;
      slash_r  <= slash_nxt;
      held_r   <= held_nxt;
      hvalid_r <= hvalid_nxt;
      hfirst_r <= hfirst_nxt;
      spos_r   <= spos_nxt;
      sline_r  <= sline_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
    end
  end

`ifndef SYNTHESIS
  // a held slash only exists between tokens
  a_slash_idle: assert property (@(posedge clk) disable iff (!rst_n)
    slash_r |-> mode_r == M_IDLE)
    else $error("slash held outside idle mode");

  // an open word always holds its last character
  a_word_held: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_WORD |-> hvalid_r)
    else $error("open word without held character");

  // end of text returns the scanner to its reset state
  a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_is_final |=> mode_r == M_IDLE && !slash_r && !hvalid_r
                           && pos_r == '0 && line_r == '0)
    else $error("state not cleared after final character");
`endif

endmodule

@@ design/slx_fifo.sv @@
// short queue of result bundles between scanner and emitter
module slx_fifo import slx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  slx_bundle_t wdata,
  output logic        full,
  input  logic        pop,
  output logic        empty,
  output slx_bundle_t rdata
);

  slx_bundle_t        mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_r, wptr_nxt;
  logic [FIFO_AW-1:0] rptr_r, rptr_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  // pointer and fill count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = rptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // bundle storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  // the scanner never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("bundle pushed into full queue");
`endif

endmodule

@@ design/slx_emit.sv @@
// back end: hands out the words of the oldest bundle one at a time
module slx_emit import slx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        bnd_empty,
  input  slx_bundle_t bnd,
  output logic        bnd_pop,
  input  logic        out_pop,
  output logic        out_empty,
  output slx_item_t   item,
  output logic        run_last
);

  logic [1:0] idx_r, idx_nxt;
  logic       take;

  assign out_empty = bnd_empty;
  assign item      = bnd.items[idx_r];
  assign run_last  = (idx_r == bnd.cnt - 2'd1);
  assign take      = out_pop && !bnd_empty;
  assign bnd_pop   = take && run_last;

  // word index within the head bundle
  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = run_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

`ifndef SYNTHESIS
  // the index stays inside the head bundle
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    !bnd_empty |-> bnd.cnt != 2'd0 && idx_r < bnd.cnt)
    else $error("word index beyond head bundle");
`endif

endmodule

@@ design/script_lexer.sv @@
// top level of the streaming script lexer
//
// Input channel: one text character per word on in_char, with in_is_final
// marking the last character of a text. A word is taken on a clock edge
// with in_push high and in_full low; one character can be taken per cycle.
// Result channel: token characters leave as words, oldest first, while
// out_empty is low; out_pop takes the word on the ports. Each character
// causes zero to three result words; out_run_last marks the last of them.
// The words of a character reach the ports behind those of older ones.
// Throughput: one character per cycle on the input while in_full is low;
// one word per cycle on the output while out_pop is high and out_empty is
// low; the output sets the pace when characters cause more than one word.
// A four-bundle queue sits between the scanner and the emitter, so the
// scanner keeps taking characters while the receiver stalls, until the
// queue fills and in_full rises.
// Reset (rst_n low, synchronous) clears the scanner to the between-tokens
// state with offset and line at zero and empties the queue. After a final
// character the scanner returns to that same state on its own.
module script_lexer import slx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [7:0]        in_char,
  input  logic              in_is_final,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [1:0]        out_token_kind,
  output logic [7:0]        out_token_char,
  output logic              out_char_present,
  output logic              out_token_first,
  output logic              out_token_end,
  output logic [POS_W-1:0]  out_token_offset,
  output logic [LINE_W-1:0] out_token_line,
  output logic              out_run_last
);

  logic        acc;
  logic        bnd_push;
  logic        bnd_pop;
  logic        bnd_full;
  logic        bnd_empty;
  slx_bundle_t bnd_in;
  slx_bundle_t bnd_head;
  slx_item_t   item;

  assign in_full = bnd_full;
  assign acc     = in_push && !bnd_full;

  // front end
  slx_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .in_char     (in_char),
    .in_is_final (in_is_final),
    .bnd_push    (bnd_push),
    .bnd         (bnd_in)
  );

  // decoupling queue
  slx_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (bnd_push),
    .wdata (bnd_in),
    .full  (bnd_full),
    .pop   (bnd_pop),
    .empty (bnd_empty),
    .rdata (bnd_head)
  );

  // back end
  slx_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .bnd_empty (bnd_empty),
    .bnd       (bnd_head),
    .bnd_pop   (bnd_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .item      (item),
    .run_last  (out_run_last)
  );

  // result fields
  assign out_token_kind   = item.kind;
  assign out_token_char   = item.ch;
  assign out_char_present = item.present;
  assign out_token_first  = item.first;
  assign out_token_end    = item.tend;
  assign out_token_offset = item.offset;
  assign out_token_line   = item.line;

endmodule
